// File: rtl/psmms_pkg.sv
// shared types and constants for the parity sort merge mean split block
`default_nettype none
package psmms_pkg;
   localparam int VALUE_W = 32;
   localparam int TAG_W   = 2;

   // list tags carried in tuser
   localparam logic [TAG_W-1:0] TAG_MERGED = 2'd0;
   localparam logic [TAG_W-1:0] TAG_BELOW  = 2'd1;
   localparam logic [TAG_W-1:0] TAG_ABOVE  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_DIV,
      ST_MRG_RD,
      ST_MRG_CMP,
      ST_OUT_RD,
      ST_OUT_WAIT,
      ST_OUT_PUT
   } state_type;
endpackage
`default_nettype wire

// File: rtl/psmms_ram.sv
// generic ram with one write port and one registered read port
`default_nettype none
module psmms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/parity_sort_merge_mean_split_top.sv
// top level: collects a set, sorts by parity, merges, splits around the mean
// per item: after accept, a read (ST_INS_RD) and a compare (ST_INS_CMP) per shifted entry through
//   the single read port of the list memory, until the next ready
// closing: restoring divider for the mean, then a read and a compare per merged entry
// output: 3 passes over the merged memory, an entry at a time; the put state holds while a result is stalled
// throughput: one item at a time; input is held off while a run is produced
// reset: synchronous, clears counts, sum and control; memories are not cleared
`default_nettype none
module parity_sort_merge_mean_split_top #(
   parameter int MAX_ITEMS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // value[31:0]
   input  wire logic        req_tlast,   // final_item
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // result_value[31:0], mean_value[63:32]
   output logic [psmms_pkg::TAG_W-1:0] rsp_tuser, // list_tag[1:0]
   output logic             rsp_tlast    // run_end
);
   import psmms_pkg::*;

   localparam int AW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW   = $clog2(MAX_ITEMS + 1);
   localparam int SW   = VALUE_W + $clog2(MAX_ITEMS) + 1;
   localparam int DEP  = 1 << AW;
   localparam int DCW  = $clog2(SW + 1);
   localparam int TW   = $clog2(3 * MAX_ITEMS + 1);

   state_type state_ff, state_in;

   logic [CW-1:0] ecnt_ff, ocnt_ff, icnt_ff, ecnt_in, ocnt_in, icnt_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic last_ff, last_in, odd_ff, odd_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] ei_ff, ei_in, oi_ff, oi_in, m_ff, m_in;
   // divider state: magnitude quotient by restoring shift-subtract
   logic [SW-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [DCW-1:0] dstep_ff, dstep_in;
   logic neg_ff, neg_in;
   logic signed [VALUE_W-1:0] mean_ff, mean_in;
   logic [1:0] pass_ff, pass_in;
   logic [CW-1:0] oidx_ff, oidx_in;
   logic [VALUE_W-1:0] hold_ff, hold_in;
   logic [63:0] rdata_ff, rdata_in;
   logic [TAG_W-1:0] ruser_ff, ruser_in;
   logic rvalid_ff, rvalid_in, rlast_ff, rlast_in;
   // items in the run and items emitted so far
   logic [TW-1:0] tot_ff, tot_in, emit_ff, emit_in;

   // memory ports
   logic e_we, o_we, m_we;
   logic [AW-1:0] e_wa, o_wa, m_wa, e_ra, o_ra, m_ra;
   logic [VALUE_W-1:0] e_wd, o_wd, m_wd, e_rd, o_rd, m_rd;

   psmms_ram #(.WIDTH(VALUE_W), .DEPTH(DEP)) u_even (
      .clock(clock), .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd),
      .rd_addr(e_ra), .rd_data(e_rd));
   psmms_ram #(.WIDTH(VALUE_W), .DEPTH(DEP)) u_odd (
      .clock(clock), .wr_en(o_we), .wr_addr(o_wa), .wr_data(o_wd),
      .rd_addr(o_ra), .rd_data(o_rd));
   psmms_ram #(.WIDTH(VALUE_W), .DEPTH(DEP)) u_merged (
      .clock(clock), .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
      .rd_addr(m_ra), .rd_data(m_rd));

   logic signed [VALUE_W-1:0] rd_sel;
   logic [SW-1:0] sum_mag, rem_sh;
   logic [SW-1:0] div_d;
   logic keep;
   logic [CW-1:0] pos_m1;

   assign rd_sel  = odd_ff ? o_rd : e_rd;
   assign pos_m1  = pos_ff - 1'b1;
   assign sum_mag = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
   assign div_d   = SW'(icnt_ff);
   assign rem_sh  = {rem_ff[SW-2:0], quo_ff[SW-1]};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_INS_RD;
            end
         end
         ST_INS_RD: begin
            if (pos_ff == '0 || pos_ff >= CW'(MAX_ITEMS)) begin
               state_in = (last_ff || icnt_ff == CW'(MAX_ITEMS)) ? ST_DIV : ST_IDLE;
            end else begin
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (rd_sel > val_ff) begin
               state_in = ST_INS_RD;
            end else begin
               state_in = (last_ff || icnt_ff == CW'(MAX_ITEMS)) ? ST_DIV : ST_IDLE;
            end
         end
         ST_DIV: begin
            if (dstep_ff == DCW'(SW)) begin
               state_in = ST_MRG_RD;
            end
         end
         ST_MRG_RD: begin
            state_in = (ei_ff == ecnt_ff && oi_ff == ocnt_ff) ? ST_OUT_RD : ST_MRG_CMP;
         end
         ST_MRG_CMP: state_in = ST_MRG_RD;
         ST_OUT_RD: begin
            state_in = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: state_in = ST_OUT_PUT;
         ST_OUT_PUT: begin
            if (!rvalid_ff || rsp_tready) begin
               if (oidx_ff + 1'b1 == m_ff && pass_ff == 2'd2) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      ecnt_in = ecnt_ff; ocnt_in = ocnt_ff; icnt_in = icnt_ff; sum_in = sum_ff;
      val_in = val_ff; last_in = last_ff; odd_in = odd_ff; pos_in = pos_ff;
      ei_in = ei_ff; oi_in = oi_ff; m_in = m_ff;
      rem_in = rem_ff; quo_in = quo_ff; dstep_in = dstep_ff; neg_in = neg_ff;
      mean_in = mean_ff; pass_in = pass_ff; oidx_in = oidx_ff; hold_in = hold_ff;
      rdata_in = rdata_ff; ruser_in = ruser_ff; rlast_in = rlast_ff;
      tot_in = tot_ff; emit_in = emit_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      e_we = 1'b0; o_we = 1'b0; m_we = 1'b0;
      e_wa = pos_ff[AW-1:0]; o_wa = pos_ff[AW-1:0]; m_wa = m_ff[AW-1:0];
      e_wd = val_ff; o_wd = val_ff; m_wd = e_rd;
      e_ra = pos_m1[AW-1:0]; o_ra = pos_m1[AW-1:0]; m_ra = oidx_ff[AW-1:0];
      req_tready = (state_ff == ST_IDLE);
      keep = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               val_in  = $signed(req_tdata);
               last_in = req_tlast;
               odd_in  = req_tdata[0];
               pos_in  = req_tdata[0] ? ocnt_ff : ecnt_ff;
               sum_in  = sum_ff + SW'($signed(req_tdata));
               icnt_in = icnt_ff + 1'b1;
            end
         end
         ST_INS_RD: begin
            // read the entry below the hole, or drop the value in place
            if (pos_ff == '0 || pos_ff >= CW'(MAX_ITEMS)) begin
               if (pos_ff < CW'(MAX_ITEMS)) begin
                  e_we = !odd_ff; o_we = odd_ff;
                  if (odd_ff) ocnt_in = ocnt_ff + 1'b1;
                  else ecnt_in = ecnt_ff + 1'b1;
               end
            end
         end
         ST_INS_CMP: begin
            // shift the larger entry up, else place the value
            if (rd_sel > val_ff) begin
               e_we = !odd_ff; o_we = odd_ff;
               e_wd = rd_sel; o_wd = rd_sel;
               pos_in = pos_m1;
            end else begin
               e_we = !odd_ff; o_we = odd_ff;
               if (odd_ff) ocnt_in = ocnt_ff + 1'b1;
               else ecnt_in = ecnt_ff + 1'b1;
            end
         end
         ST_DIV: begin
            // one quotient bit a cycle on magnitudes
            if (dstep_ff == '0) begin
               rem_in = '0; quo_in = sum_mag; neg_in = sum_ff[SW-1];
               dstep_in = dstep_ff + 1'b1;
            end else if (dstep_ff <= DCW'(SW - 1) + 1'b0 && dstep_ff != DCW'(SW)) begin
               quo_in = {quo_ff[SW-2:0], 1'b0};
               if (rem_sh >= div_d) begin
                  rem_in = rem_sh - div_d; quo_in[0] = 1'b1;
               end else begin
                  rem_in = rem_sh;
               end
               dstep_in = dstep_ff + 1'b1;
            end else begin
               quo_in = {quo_ff[SW-2:0], 1'b0};
               if (rem_sh >= div_d) quo_in[0] = 1'b1;
               mean_in = neg_ff ? VALUE_W'(-quo_in) : VALUE_W'(quo_in);
               dstep_in = '0; ei_in = '0; oi_in = '0; m_in = '0;
               tot_in = '0;
            end
         end
         ST_MRG_RD: begin
            e_ra = ei_ff[AW-1:0]; o_ra = oi_ff[AW-1:0];
            if (ei_ff == ecnt_ff && oi_ff == ocnt_ff) begin
               pass_in = 2'd0; oidx_in = '0; emit_in = '0;
            end
         end
         ST_MRG_CMP: begin
            // odd wins ties
            m_we = 1'b1;
            if (oi_ff == ocnt_ff || (ei_ff != ecnt_ff && $signed(e_rd) < $signed(o_rd))) begin
               m_wd = e_rd; ei_in = ei_ff + 1'b1;
            end else begin
               m_wd = o_rd; oi_in = oi_ff + 1'b1;
            end
            m_in = m_ff + 1'b1;
            // merged item, plus one split item unless equal to the mean
            tot_in = tot_ff + (($signed(m_wd) != mean_ff) ? TW'(2) : TW'(1));
         end
         ST_OUT_RD: ;
         ST_OUT_WAIT: hold_in = m_rd;
         ST_OUT_PUT: begin
            // emit if selected by the current pass
            keep = (pass_ff == 2'd0) || (pass_ff == 2'd1 && $signed(hold_ff) < mean_ff)
                   || (pass_ff == 2'd2 && $signed(hold_ff) > mean_ff);
            if (!rvalid_ff || rsp_tready) begin
               if (keep) begin
                  rvalid_in = 1'b1;
                  rdata_in  = {mean_ff, hold_ff};
                  ruser_in  = (pass_ff == 2'd0) ? TAG_MERGED :
                              (pass_ff == 2'd1) ? TAG_BELOW : TAG_ABOVE;
                  // run end flag on the last item of the run
                  rlast_in  = (emit_ff + 1'b1 == tot_ff);
                  emit_in   = emit_ff + 1'b1;
               end
               if (oidx_ff + 1'b1 == m_ff) begin
                  oidx_in = '0; pass_in = pass_ff + 1'b1;
                  if (pass_ff == 2'd2) begin
                     ecnt_in = '0; ocnt_in = '0; icnt_in = '0; sum_in = '0;
                  end
               end else begin
                  oidx_in = oidx_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ecnt_ff <= '0; ocnt_ff <= '0; icnt_ff <= '0; sum_ff <= '0;
         dstep_ff <= '0; rvalid_ff <= 1'b0; rlast_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ecnt_ff <= ecnt_in; ocnt_ff <= ocnt_in; icnt_ff <= icnt_in; sum_ff <= sum_in;
         dstep_ff <= dstep_in; rvalid_ff <= rvalid_in; rlast_ff <= rlast_in;
      end
      val_ff <= val_in; last_ff <= last_in; odd_ff <= odd_in; pos_ff <= pos_in;
      ei_ff <= ei_in; oi_ff <= oi_in; m_ff <= m_in;
      rem_ff <= rem_in; quo_ff <= quo_in; neg_ff <= neg_in; mean_ff <= mean_in;
      pass_ff <= pass_in; oidx_ff <= oidx_in; hold_ff <= hold_in;
      rdata_ff <= rdata_in; ruser_ff <= ruser_in;
      tot_ff <= tot_in; emit_ff <= emit_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = ruser_ff;
   assign rsp_tlast  = rlast_ff;

   // no input accepted while a run is being produced
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("input accepted while busy");
   // counts never exceed the list depth
   assert property (@(posedge clock) disable iff (reset)
      (ecnt_ff <= CW'(MAX_ITEMS)) && (ocnt_ff <= CW'(MAX_ITEMS)))
      else $error("list count overflow");
   // a waiting result holds while stalled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result changed under stall");
endmodule
`default_nettype wire
